// ----- design/point_in_polygon_crossing_core_assert.svh -----
// Assertion macros for the point-in-polygon crossing core
`ifndef POINT_IN_POLYGON_CROSSING_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define PIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pip_pkg.sv -----
// Shared types, constants and helper functions for the point-in-polygon core
`default_nettype none

package pip_pkg;

    localparam int CW = 32;        // coordinate width used from each field
    localparam int FW = 32;        // field width at the ports
    localparam int DW = CW + 1;    // edge difference width
    localparam int PW = 2 * DW;    // cross product width

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [PW-1:0] t_prod;

    typedef enum logic [1:0] {
        AXIS_YZ = 2'd0,
        AXIS_ZX = 2'd1,
        AXIS_XY = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        CMD_POINT  = 2'd0,
        CMD_NORMAL = 2'd1,
        CMD_VERTEX = 2'd2
    } t_cmd;

    typedef struct packed {
        t_coord u;
        t_coord v;
    } t_uv;

    // one edge test: query point p, edge from a to b
    typedef struct packed {
        logic act;
        t_uv  p;
        t_uv  a;
        t_uv  b;
    } t_edge_req;

    function automatic t_coord ext_coord(input logic [FW-1:0] raw);
        logic signed [63:0] w;
        begin
            w = 64'(signed'(raw));
            return w[CW-1:0];
        end
    endfunction

    function automatic logic [CW-1:0] mag(input t_coord x);
        logic [CW-1:0] u;
        begin
            u = x;
            return u[CW-1] ? (~u + CW'(1)) : u;
        end
    endfunction

    // largest normal component picks the dropped axis
    function automatic t_axis pick_axis(input t_coord nx, input t_coord ny, input t_coord nz);
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] az;
        begin
            ax = mag(nx);
            ay = mag(ny);
            az = mag(nz);
            if (ax > ay) begin
                if (ay > az || ax > az) begin
                    return AXIS_YZ;
                end
                return AXIS_XY;
            end
            if (ax > az || ay > az) begin
                return AXIS_ZX;
            end
            return AXIS_XY;
        end
    endfunction

    function automatic t_uv project(input t_axis axis, input t_coord x, input t_coord y,
                                    input t_coord z);
        t_uv r;
        begin
            case (axis)
                AXIS_YZ: begin
                    r.u = y;
                    r.v = z;
                end
                AXIS_ZX: begin
                    r.u = z;
                    r.v = x;
                end
                default: begin
                    r.u = x;
                    r.v = y;
                end
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/point_in_polygon_crossing_core.sv -----
// Point-in-polygon crossing parity core, top level
// A result reaches the output register after the last vertex passes the front and edge stage registers.
// Throughput: one request per cycle of any command unless o_ready is low; the two cross products of each
// edge sit in their own register stage, the parity bit updates in the final stage.
// Output register lets requests keep flowing while a result waits, until stages fill.
// Reset (synchronous, active low): point zero, XY plane, parity clear, pipeline empty.
`default_nettype none
`include "point_in_polygon_crossing_core_assert.svh"

module point_in_polygon_crossing_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire [1:0]               i_command,
    input  wire [pip_pkg::FW-1:0]   i_coord_x,
    input  wire [pip_pkg::FW-1:0]   i_coord_y,
    input  wire [pip_pkg::FW-1:0]   i_coord_z,
    input  wire                     i_last_vertex,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic                    o_inside_res,
    output logic [1:0]              o_plane_axis
);

    logic               w_v1, w_last1;
    pip_pkg::t_axis     w_axis1;
    pip_pkg::t_edge_req w_edge_prev, w_edge_close;
    logic               w_tog_prev, w_tog_close;

    logic               r_v2, r_v3;
    logic               r_last2, r_last3;
    pip_pkg::t_axis     r_axis2, r_axis3;
    logic               r_parity;
    logic               r_out_valid;
    logic               r_inside;
    pip_pkg::t_axis     r_out_axis;

    logic               w_slot_free, w_adv3, w_s3_ready, w_adv2, w_s2_ready, w_adv1;
    logic               w_accept, w_par_new;

    always_comb begin
        w_slot_free = !r_out_valid || i_ready;
        w_adv3      = r_v3 && (!r_last3 || w_slot_free);
        w_s3_ready  = !r_v3 || w_adv3;
        w_adv2      = r_v2 && w_s3_ready;
        w_s2_ready  = !r_v2 || w_s3_ready;
        w_adv1      = w_v1 && w_s2_ready;
        o_ready     = !w_v1 || w_s2_ready;
        w_accept    = i_valid && o_ready;
        w_par_new   = r_parity ^ w_tog_prev ^ w_tog_close;
    end

    pip_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_command    (i_command),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_last_vertex(i_last_vertex),
        .i_advance    (w_adv1),
        .o_valid      (w_v1),
        .o_edge_prev  (w_edge_prev),
        .o_edge_close (w_edge_close),
        .o_last       (w_last1),
        .o_axis       (w_axis1)
    );

    pip_edge u_edge_prev (
        .i_clk   (i_clk),
        .i_load2 (w_adv1),
        .i_load3 (w_adv2),
        .i_req   (w_edge_prev),
        .o_toggle(w_tog_prev)
    );

    pip_edge u_edge_close (
        .i_clk   (i_clk),
        .i_load2 (w_adv1),
        .i_load3 (w_adv2),
        .i_req   (w_edge_close),
        .o_toggle(w_tog_close)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v2 <= 1'b1;
            end else if (w_adv2) begin
                r_v2 <= 1'b0;
            end
            if (w_adv2) begin
                r_v3 <= 1'b1;
            end else if (w_adv3) begin
                r_v3 <= 1'b0;
            end
            if (w_adv3) begin
                r_parity <= r_last3 ? 1'b0 : w_par_new;
            end
            if (w_adv3 && r_last3) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_last2 <= w_last1;
            r_axis2 <= w_axis1;
        end
        if (w_adv2) begin
            r_last3 <= r_last2;
            r_axis3 <= r_axis2;
        end
        if (w_adv3 && r_last3) begin
            r_inside   <= w_par_new;
            r_out_axis <= r_axis3;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_plane_axis = r_out_axis;

    `PIP_ASSERT_NOW(a_result_from_last, i_clk, i_rst_n, $rose(r_out_valid), $past(w_adv3 && r_last3), "result without a closing vertex")
    `PIP_ASSERT_NEXT(a_parity_cleared, i_clk, i_rst_n, w_adv3 && r_last3, r_parity == 1'b0, "parity not cleared after result")
    `PIP_ASSERT_NEXT(a_stage3_held, i_clk, i_rst_n, r_v3 && !w_adv3, r_v3 && $stable(r_last3), "stage 3 dropped while stalled")
    `PIP_ASSERT_NOW(a_no_result_overrun, i_clk, i_rst_n, r_out_valid && !i_ready, !(w_adv3 && r_last3), "result overwrites a pending one")

endmodule

`default_nettype wire

// ----- design/pip_front.sv -----
// Command decode, polygon state and first pipeline register
`default_nettype none

module pip_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  wire [1:0]               i_command,
    input  wire [pip_pkg::FW-1:0]   i_coord_x,
    input  wire [pip_pkg::FW-1:0]   i_coord_y,
    input  wire [pip_pkg::FW-1:0]   i_coord_z,
    input  wire                     i_last_vertex,
    input  wire                     i_advance,
    output logic                    o_valid,
    output pip_pkg::t_edge_req      o_edge_prev,
    output pip_pkg::t_edge_req      o_edge_close,
    output logic                    o_last,
    output pip_pkg::t_axis          o_axis
);

    pip_pkg::t_coord    r_qx, r_qy, r_qz;
    pip_pkg::t_axis     r_axis;
    pip_pkg::t_uv       r_first_uv;
    pip_pkg::t_uv       r_prev_uv;
    logic               r_await;
    logic               r_v1;
    pip_pkg::t_edge_req r_edge_prev, r_edge_close;
    logic               r_last;
    pip_pkg::t_axis     r_axis1;

    pip_pkg::t_coord    w_cx, w_cy, w_cz;
    pip_pkg::t_uv       w_cur;
    pip_pkg::t_uv       w_query;
    pip_pkg::t_uv       w_first_eff;
    pip_pkg::t_cmd      w_cmd;
    logic               w_vertex;

    always_comb begin
        w_cx        = pip_pkg::ext_coord(i_coord_x);
        w_cy        = pip_pkg::ext_coord(i_coord_y);
        w_cz        = pip_pkg::ext_coord(i_coord_z);
        w_cmd       = pip_pkg::t_cmd'(i_command);
        w_cur       = pip_pkg::project(r_axis, w_cx, w_cy, w_cz);
        w_query     = pip_pkg::project(r_axis, r_qx, r_qy, r_qz);
        w_first_eff = r_await ? w_cur : r_first_uv;
        w_vertex    = i_accept && (w_cmd == pip_pkg::CMD_VERTEX);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx    <= '0;
            r_qy    <= '0;
            r_qz    <= '0;
            r_axis  <= pip_pkg::AXIS_XY;
            r_await <= 1'b1;
            r_v1    <= 1'b0;
        end else begin
            if (i_accept) begin
                case (w_cmd)
                    pip_pkg::CMD_POINT: begin
                        r_qx <= w_cx;
                        r_qy <= w_cy;
                        r_qz <= w_cz;
                    end
                    pip_pkg::CMD_NORMAL: begin
                        r_axis <= pip_pkg::pick_axis(w_cx, w_cy, w_cz);
                    end
                    pip_pkg::CMD_VERTEX: begin
                        r_await <= i_last_vertex;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_vertex) begin
                r_v1 <= 1'b1;
            end else if (i_advance) begin
                r_v1 <= 1'b0;
            end
        end
    end

    // vertex store and stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_vertex) begin
            if (r_await) begin
                r_first_uv <= w_cur;
            end
            r_prev_uv          <= w_cur;
            r_edge_prev.act    <= !r_await;
            r_edge_prev.p      <= w_query;
            r_edge_prev.a      <= r_prev_uv;
            r_edge_prev.b      <= w_cur;
            // closing edge runs from this vertex back to the first
            r_edge_close.act   <= i_last_vertex;
            r_edge_close.p     <= w_query;
            r_edge_close.a     <= w_cur;
            r_edge_close.b     <= w_first_eff;
            r_last             <= i_last_vertex;
            r_axis1            <= r_axis;
        end
    end

    assign o_valid      = r_v1;
    assign o_edge_prev  = r_edge_prev;
    assign o_edge_close = r_edge_close;
    assign o_last       = r_last;
    assign o_axis       = r_axis1;

endmodule

`default_nettype wire

// ----- design/pip_edge.sv -----
// One edge crossing test: differences, cross products, signed compare
`default_nettype none

module pip_edge (
    input  wire                 i_clk,
    input  wire                 i_load2,
    input  wire                 i_load3,
    input  pip_pkg::t_edge_req  i_req,
    output logic                o_toggle
);

    logic           r_act2, r_pos2, r_neg2;
    pip_pkg::t_diff r_ah, r_dv, r_bh, r_dq;
    logic           r_act3, r_pos3, r_neg3;
    pip_pkg::t_prod r_m1, r_m2;

    logic           w_cross;
    pip_pkg::t_diff w_ah, w_dv, w_bh, w_dq;

    always_comb begin
        // half-open rule on v
        w_cross = (i_req.p.v >= i_req.b.v && i_req.p.v < i_req.a.v) ||
                  (i_req.p.v >= i_req.a.v && i_req.p.v < i_req.b.v);
        w_dv = {i_req.b.v[pip_pkg::CW-1], i_req.b.v} - {i_req.a.v[pip_pkg::CW-1], i_req.a.v};
        w_ah = {i_req.p.u[pip_pkg::CW-1], i_req.p.u} - {i_req.a.u[pip_pkg::CW-1], i_req.a.u};
        w_bh = {i_req.b.u[pip_pkg::CW-1], i_req.b.u} - {i_req.a.u[pip_pkg::CW-1], i_req.a.u};
        w_dq = {i_req.p.v[pip_pkg::CW-1], i_req.p.v} - {i_req.a.v[pip_pkg::CW-1], i_req.a.v};
    end

    always_ff @(posedge i_clk) begin
        if (i_load2) begin
            r_act2 <= i_req.act && w_cross;
            r_pos2 <= !w_dv[pip_pkg::DW-1] && (w_dv != '0);
            r_neg2 <= w_dv[pip_pkg::DW-1];
            r_ah   <= w_ah;
            r_dv   <= w_dv;
            r_bh   <= w_bh;
            r_dq   <= w_dq;
        end
        if (i_load3) begin
            r_act3 <= r_act2;
            r_pos3 <= r_pos2;
            r_neg3 <= r_neg2;
            r_m1   <= pip_pkg::PW'(r_ah) * pip_pkg::PW'(r_dv);
            r_m2   <= pip_pkg::PW'(r_bh) * pip_pkg::PW'(r_dq);
        end
    end

    assign o_toggle = r_act3 && ((r_pos3 && (r_m1 < r_m2)) || (r_neg3 && (r_m2 < r_m1)));

endmodule

`default_nettype wire
